### sv/mrrc_pkg.sv
// Package for the Modbus RTU reply checker: codes, result type and constants.
// Used by mrrc_crc16, mrrc_frame and modbus_rtu_reply_checker; depends on nothing.
package mrrc_pkg;

    localparam int unsigned FRAME_BYTES_DEF = 13;
    localparam int unsigned IDX_W           = 4;
    localparam int unsigned WORD_W          = 16;
    localparam int unsigned NUM_WORDS       = 4;

    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [7:0]  DEV_ADDR_RST      = 8'h01;
    localparam logic [15:0] TIMEOUT_RST       = 16'd1000;
    localparam logic [15:0] TICK_MAX          = 16'hFFFF;

    // Configuration register indexes.
    localparam logic CFG_DEV_ADDR = 1'b0;
    localparam logic CFG_TIMEOUT  = 1'b1;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_HEADER  = 2'd2,
        ST_CRC     = 2'd3
    } t_status;

    typedef struct packed {
        t_status                           status;
        logic [NUM_WORDS-1:0][WORD_W-1:0]  words;
    } t_result;

endpackage

### sv/modbus_rtu_reply_checker.sv
// Top level of the Modbus RTU read-registers reply checker: input register,
// configuration registers, frame tracker and result register. Depends on mrrc_pkg, mrrc_frame.
//
//  Channel   Direction  Handshake            Payload
//  input     in         i_valid / o_stall    i_opcode, i_rx_byte
//  result    out        o_valid / i_stall    o_status, o_moisture_tenths, o_temperature_tenths,
//                                            o_conductivity, o_ph_tenths
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One item is taken every cycle while o_stall is low. An item lands in the input register; when
// it moves on, the frame tracker updates its state and, if the item ends the reply or times it
// out, loads the result register at the same edge, so a result passes through the input register
// and the result register on its way to the outputs. The per-cycle limit is the CRC byte update,
// eight combinational shift stages. Reset is synchronous and needs no clearing pass; the block is
// ready as soon as reset is released. A stalled result holds in the result register while the
// input register still takes one more item; o_stall rises only when both are full.
module modbus_rtu_reply_checker
    import mrrc_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel.
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic [7:0]         i_rx_byte,
    // Result channel.
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic [15:0]        o_moisture_tenths,
    output logic signed [15:0] o_temperature_tenths,
    output logic [15:0]        o_conductivity,
    output logic [15:0]        o_ph_tenths,
    // Configuration write port.
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);

    // Input register.
    logic        r_s1_valid;
    logic [1:0]  r_s1_op;
    logic [7:0]  r_s1_byte;

    // Configuration registers.
    logic [7:0]  r_dev_addr;
    logic [15:0] r_timeout;

    // Result register.
    logic        r_out_valid;
    t_result     r_out;

    logic        advance;
    logic        accept;
    logic        res_valid;
    t_result     res;

    // The held item moves on whenever the result register is empty or is being drained.
    assign advance = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !advance;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op   <= i_opcode;
            r_s1_byte <= i_rx_byte;
        end
    end

    // Configuration writes apply at once; the user makes them only while idle (not enforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RST;
            r_timeout  <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEV_ADDR: r_dev_addr <= i_cfg_data[7:0];
                CFG_TIMEOUT:  r_timeout  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mrrc_frame #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (advance),
        .i_opcode    (r_s1_op),
        .i_rx_byte   (r_s1_byte),
        .i_dev_addr  (r_dev_addr),
        .i_timeout   (r_timeout),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // The result register is loaded only when a result is produced; otherwise a completed
    // transfer empties it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_status             = r_out.status;
    assign o_moisture_tenths    = r_out.words[0];
    assign o_temperature_tenths = signed'(r_out.words[1]);
    assign o_conductivity       = r_out.words[2];
    assign o_ph_tenths          = r_out.words[3];

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid)
        else $error("input stalled with an empty input register");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_stall) |-> o_stall)
        else $error("input taken while both registers are held");

    a_result_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && res_valid) |=> o_valid)
        else $error("produced result did not reach the result register");

endmodule

### sv/mrrc_crc16.sv
// Modbus CRC16 update for one byte: eight reflected shift stages, all combinational.
// Depends on mrrc_pkg for the polynomial.
module mrrc_crc16
    import mrrc_pkg::*;
(
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    logic [8:0][15:0] stage;

    assign stage[0] = i_crc ^ {8'h00, i_byte};

    // Each stage shifts right once and folds in the polynomial when a one drops out.
    for (genvar k = 0; k < 8; k++) begin : g_shift
        assign stage[k+1] = stage[k][0] ? ((stage[k] >> 1) ^ CRC_POLY) : (stage[k] >> 1);
    end

    assign o_crc = stage[8];

endmodule

### sv/mrrc_frame.sv
// Frame tracker: reply state, header check, word capture, timeout and verdict.
// Depends on mrrc_pkg and mrrc_crc16.
module mrrc_frame
    import mrrc_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_dev_addr,
    input  logic [15:0] i_timeout,
    output logic        o_res_valid,
    output t_result     o_res
);

    localparam logic [IDX_W-1:0] CRC_LO_IDX = IDX_W'(FRAME_BYTES - 2);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(FRAME_BYTES - 1);
    localparam logic [IDX_W-1:0] FIRST_WORD = IDX_W'(3);
    localparam logic [IDX_W-1:0] LAST_WORD  = IDX_W'(3 + 2 * NUM_WORDS - 1);

    logic                             r_busy, n_busy;
    logic [IDX_W-1:0]                 r_byte_index, n_byte_index;
    logic [15:0]                      r_crc, n_crc;
    logic                             r_header_bad, n_header_bad;
    logic [15:0]                      r_ticks, n_ticks;
    logic [NUM_WORDS-1:0][WORD_W-1:0] r_words, n_words;
    logic [7:0]                       r_crc_low, n_crc_low;

    logic [15:0]      crc_next;
    logic [15:0]      tick_inc;
    logic             hdr_bad;
    logic [IDX_W-1:0] word_off;
    logic [1:0]       word_sel;
    logic             status_ok;

    mrrc_crc16 u_crc (
        .i_crc  (r_crc),
        .i_byte (i_rx_byte),
        .o_crc  (crc_next)
    );

    assign tick_inc = (r_ticks == TICK_MAX) ? r_ticks : r_ticks + 16'd1;
    assign hdr_bad  = r_header_bad
                    | ((r_byte_index == IDX_W'(0)) && (i_rx_byte != i_dev_addr))
                    | ((r_byte_index == IDX_W'(1)) && (i_rx_byte != FUNC_READ_HOLDING));
    assign word_off = r_byte_index - FIRST_WORD;
    assign word_sel = word_off[2:1];

    always_comb begin
        n_busy       = r_busy;
        n_byte_index = r_byte_index;
        n_crc        = r_crc;
        n_header_bad = r_header_bad;
        n_ticks      = r_ticks;
        n_words      = r_words;
        n_crc_low    = r_crc_low;
        o_res_valid  = 1'b0;
        o_res.status = ST_OK;
        status_ok    = 1'b0;
        o_res.words  = '0;
        if (i_valid) begin
            case (i_opcode)
                OP_START: begin
                    n_busy       = 1'b1;
                    n_byte_index = '0;
                    n_crc        = CRC_INIT;
                    n_header_bad = 1'b0;
                    n_ticks      = '0;
                    n_words      = '0;
                    n_crc_low    = '0;
                end
                OP_TICK: begin
                    if (r_busy) begin
                        n_ticks = tick_inc;
                        if (tick_inc >= i_timeout) begin
                            o_res_valid  = 1'b1;
                            o_res.status = ST_TIMEOUT;
                            n_busy       = 1'b0;
                        end
                    end
                end
                OP_BYTE: begin
                    if (r_busy) begin
                        n_header_bad = hdr_bad;
                        if (r_byte_index < CRC_LO_IDX) begin
                            n_crc        = crc_next;
                            n_byte_index = r_byte_index + IDX_W'(1);
                            if (r_byte_index >= FIRST_WORD && r_byte_index <= LAST_WORD) begin
                                // Big-endian: even offset is the high byte.
                                if (word_off[0]) begin
                                    n_words[word_sel][7:0] = i_rx_byte;
                                end else begin
                                    n_words[word_sel][15:8] = i_rx_byte;
                                end
                            end
                        end else if (r_byte_index == CRC_LO_IDX) begin
                            n_crc_low    = i_rx_byte;
                            n_byte_index = r_byte_index + IDX_W'(1);
                        end else begin
                            o_res_valid = 1'b1;
                            if (hdr_bad) begin
                                o_res.status = ST_HEADER;
                            end else if ({i_rx_byte, r_crc_low} != r_crc) begin
                                o_res.status = ST_CRC;
                            end else begin
                                o_res.status = ST_OK;
                                status_ok    = 1'b1;
                            end
                            if (status_ok) begin
                                o_res.words = r_words;
                            end
                            n_busy       = 1'b0;
                            n_byte_index = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_byte_index <= '0;
            r_crc        <= CRC_INIT;
            r_header_bad <= 1'b0;
            r_ticks      <= '0;
        end else begin
            r_busy       <= n_busy;
            r_byte_index <= n_byte_index;
            r_crc        <= n_crc;
            r_header_bad <= n_header_bad;
            r_ticks      <= n_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        r_words   <= n_words;
        r_crc_low <= n_crc_low;
    end

    a_index_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_byte_index <= LAST_IDX))
        else $error("byte index ran past the end of the frame");

    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !r_busy)
        else $error("still busy after a result was given");

    a_fail_zero_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status != ST_OK) |-> (o_res.words == '0))
        else $error("failed reply carries nonzero register values");

endmodule
